### sv/sbcr_pkg.sv
// ----------------------------------------------------------------------------
// sbcr_pkg
// shared constants, types and the arctangent table of the bin crusher
// ----------------------------------------------------------------------------
package sbcr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GROUP_MAX_DEF    = 64;

  localparam int GUARD_BITS = 4;
  localparam int INV_GAIN_W = 24;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN = 24'd10188014;
  localparam int GAIN_SH    = INV_GAIN_W + GUARD_BITS;

  // fine angle units, pi = 2^23
  localparam int ZW     = 26;
  localparam int PHW    = 17;
  localparam int ATAN_W = 22;
  localparam int STEP_W = 5;
  localparam logic signed [ZW-1:0] FINE_HALF_PI = 26'sd4194304;

  localparam int GROUP_SIZE_W = 7;
  localparam int ROBOT_W      = 9;
  localparam logic [ROBOT_W-1:0] ROBOT_FULL = 9'd256;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 9;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GROUP_SIZE   = 1'b0,
    CFG_ROBOT_AMOUNT = 1'b1
  } cfg_addr_e;

  typedef struct packed {
    logic start;
    logic vec;    // 1 = vectoring, 0 = rotation
  } cordic_ctl_t;

  function automatic logic [ATAN_W-1:0] atan_fine(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:    r = 22'd2097152;
      5'd1:    r = 22'd1238021;
      5'd2:    r = 22'd654136;
      5'd3:    r = 22'd332050;
      5'd4:    r = 22'd166669;
      5'd5:    r = 22'd83416;
      5'd6:    r = 22'd41718;
      5'd7:    r = 22'd20860;
      5'd8:    r = 22'd10430;
      5'd9:    r = 22'd5215;
      5'd10:   r = 22'd2608;
      5'd11:   r = 22'd1304;
      5'd12:   r = 22'd652;
      5'd13:   r = 22'd326;
      5'd14:   r = 22'd163;
      5'd15:   r = 22'd81;
      5'd16:   r = 22'd41;
      5'd17:   r = 22'd20;
      5'd18:   r = 22'd10;
      5'd19:   r = 22'd5;
      5'd20:   r = 22'd3;
      5'd21:   r = 22'd1;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/spectral_bin_crusher_robotiser_top.sv
// ----------------------------------------------------------------------------
// spectral_bin_crusher_robotiser_top
// bin magnitude hold and phase robotisation of complex fft bins
// ----------------------------------------------------------------------------
// One complex bin goes in on the s_axis channel per transfer, with tuser
// flagging bin zero of a frame, and one processed bin comes out on m_axis.
// Bins form groups of group_size; the first bin of a group holds its
// magnitude for the rest of the group. The phase is scaled by
// (256 - robot_amount) / 256 and the bin is rebuilt by cordic rotation.
// Registers are written on the cfg channel (index 0 group_size, index 1
// robot_amount), always ready. The user must write them only while no bin
// is in flight; the block itself does not enforce this.
// One bin at a time: a vectoring cordic pass, a bit-serial gain/phase
// multiply, a rotation pass and a second bit-serial gain multiply; the next
// bin is taken only once the result has moved into the output register.
// The output register decouples the sides: the next bin is accepted while a
// result waits; a stalled receiver holds m_axis stable and the block stops
// only when the next result is ready to be written.
// Reset clears grouping to position zero, the held magnitude to zero,
// group_size to 1 and robot_amount to 0.
// ----------------------------------------------------------------------------
module spectral_bin_crusher_robotiser_top
  import sbcr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int GROUP_MAX    = GROUP_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // bin_real, bin_imag, zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // frame_start
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_real, out_imag, zero pad
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TW   = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int XW   = SW + GUARD_BITS + 4;
  localparam int PW   = XW + INV_GAIN_W;
  localparam int RGW  = PW - GAIN_SH;
  localparam int MW   = SW + 1;
  localparam int POSW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int CW   = (POSW + 1 > GROUP_SIZE_W) ? POSW + 1 : GROUP_SIZE_W;

  localparam logic signed [ZW:0] PH_MAX = (ZW+1)'(32768);
  localparam logic signed [ZW:0] PH_MIN = -(ZW+1)'(32768);

  typedef enum logic [2:0] {
    ST_IDLE, ST_VEC, ST_VGAIN, ST_ROT, ST_RGAIN, ST_OUT
  } state_e;

  state_e                state_q;
  logic [GROUP_SIZE_W-1:0] group_size_q;
  logic [ROBOT_W-1:0]    robot_q;
  logic [POSW-1:0]       pos_q;
  logic [MW-1:0]         held_q, mag_q;
  logic signed [SW-1:0]  re_q, im_q, ore_q, oim_q;
  logic                  zero_q, own_q;
  logic signed [ZW-1:0]  t_q;
  cordic_ctl_t           cctl_q;
  logic                  mstart_q;
  logic                  m_valid_q;
  logic [TW-1:0]         m_data_q;

  // cordic and multiplier lanes
  logic signed [XW-1:0]  cx_in, cy_in, cx, cy;
  logic signed [ZW-1:0]  cz_in, cz;
  logic                  c_done;
  logic signed [XW-1:0]  ma_a, mb_a;
  logic [INV_GAIN_W-1:0] mb_b;
  logic signed [PW-1:0]  pa, pb, pa_r, pb_r;
  logic                  ma_done, mb_done;
  logic signed [PW-1:0]  pb_ph;

  logic signed [SW-1:0]  in_re, in_im;
  logic [CW-1:0]         g_eff, pos_inc;
  logic [POSW-1:0]       pos_base;
  logic [ROBOT_W-1:0]    factor;
  logic signed [ZW:0]    zr;
  logic signed [PHW-1:0] phase;
  logic signed [RGW-1:0] rga, rgb;
  logic [MW-1:0]         mag_sat, mag_sel;
  logic signed [PHW-1:0] newp;
  logic signed [SW-1:0]  sat_a, sat_b;
  logic                  accept;
  logic                  out_load;

  assign in_re  = s_axis_tdata[SW-1:0];
  assign in_im  = s_axis_tdata[2*SW-1:SW];
  assign accept = s_axis_tvalid && s_axis_tready;

  // result moves into the output register when it is free or being drained
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // group size clamp and grouping position
  always_comb begin
    g_eff = CW'(group_size_q);
    if (group_size_q == '0) begin
      g_eff = CW'(1);
    end else if (CW'(group_size_q) > CW'(GROUP_MAX)) begin
      g_eff = CW'(GROUP_MAX);
    end
    pos_base = s_axis_tuser ? '0 : pos_q;
    pos_inc  = CW'(pos_base) + 1'b1;
    factor   = (robot_q > ROBOT_FULL) ? '0 : ROBOT_FULL - robot_q;
  end

  // phase from the vectoring angle, rounded and clamped
  always_comb begin
    zr = ((ZW+1)'(cz) + (ZW+1)'(128)) >>> 8;
    if (zero_q) begin
      phase = '0;
    end else if (zr > PH_MAX) begin
      phase = PHW'(32768);
    end else if (zr < PH_MIN) begin
      phase = -PHW'(32768);
    end else begin
      phase = zr[PHW-1:0];
    end
  end

  // gain removal, rounding half up
  assign pa_r = pa + (PW'(1) <<< (GAIN_SH - 1));
  assign pb_r = pb + (PW'(1) <<< (GAIN_SH - 1));
  assign rga  = pa_r[PW-1:GAIN_SH];
  assign rgb  = pb_r[PW-1:GAIN_SH];

  always_comb begin
    if (rga[RGW-1]) begin
      mag_sat = '0;
    end else if (|rga[RGW-2:MW]) begin
      mag_sat = '1;
    end else begin
      mag_sat = rga[MW-1:0];
    end
    if (!own_q) begin
      mag_sel = held_q;
    end else if (zero_q) begin
      mag_sel = '0;
    end else begin
      mag_sel = mag_sat;
    end
  end

  // scaled phase from lane b, kept in the low bits of the product
  assign pb_ph = pb + PW'(128);
  assign newp  = pb_ph[PHW+7:8];

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [RGW-1:0] v);
    logic signed [SW-1:0] r;
    if (!v[RGW-1] && (|v[RGW-2:SW-1])) begin
      r = {1'b0, {(SW-1){1'b1}}};
    end else if (v[RGW-1] && !(&v[RGW-2:SW-1])) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  assign sat_a = sat_sw(rga);
  assign sat_b = sat_sw(rgb);

  // operand selection for the shared units
  always_comb begin
    if (state_q == ST_ROT) begin
      cx_in = XW'({mag_q, {GUARD_BITS{1'b0}}});
      cy_in = '0;
      cz_in = t_q;
    end else begin
      cx_in = XW'(re_q) <<< GUARD_BITS;
      cy_in = XW'(im_q) <<< GUARD_BITS;
      cz_in = '0;
    end
    ma_a = cx;
    if (state_q == ST_RGAIN) begin
      mb_a = cy;
      mb_b = INV_GAIN;
    end else begin
      mb_a = XW'(phase);
      mb_b = INV_GAIN_W'(factor);
    end
  end

  sbcr_cordic #(
    .XW    (XW),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl_q),
    .x_i    (cx_in),
    .y_i    (cy_in),
    .z_i    (cz_in),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz),
    .done_o (c_done)
  );

  sbcr_sermul #(
    .AW (XW),
    .BW (INV_GAIN_W)
  ) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .a_i     (ma_a),
    .b_i     (INV_GAIN),
    .done_o  (ma_done),
    .p_o     (pa)
  );

  sbcr_sermul #(
    .AW (XW),
    .BW (INV_GAIN_W)
  ) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .a_i     (mb_a),
    .b_i     (mb_b),
    .done_o  (mb_done),
    .p_o     (pb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      group_size_q <= GROUP_SIZE_W'(1);
      robot_q      <= '0;
      pos_q        <= '0;
      held_q       <= '0;
      mag_q        <= '0;
      re_q         <= '0;
      im_q         <= '0;
      ore_q        <= '0;
      oim_q        <= '0;
      zero_q       <= 1'b0;
      own_q        <= 1'b0;
      t_q          <= '0;
      cctl_q       <= '0;
      mstart_q     <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      cctl_q   <= '0;
      mstart_q <= 1'b0;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_GROUP_SIZE:   group_size_q <= cfg_data_i[GROUP_SIZE_W-1:0];
          CFG_ROBOT_AMOUNT: robot_q      <= cfg_data_i[ROBOT_W-1:0];
          default:          ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            re_q         <= in_re;
            im_q         <= in_im;
            zero_q       <= (in_re == '0) && (in_im == '0);
            own_q        <= (pos_base == '0);
            pos_q        <= (pos_inc >= g_eff) ? '0 : pos_inc[POSW-1:0];
            cctl_q.start <= 1'b1;
            cctl_q.vec   <= 1'b1;
            state_q      <= ST_VEC;
          end
        end
        ST_VEC: begin
          if (c_done) begin
            mstart_q <= 1'b1;
            state_q  <= ST_VGAIN;
          end
        end
        ST_VGAIN: begin
          if (ma_done) begin
            mag_q <= mag_sel;
            if (own_q) begin
              held_q <= mag_sel;
            end
            t_q          <= {{(ZW-PHW-8){newp[PHW-1]}}, newp, 8'b0};
            cctl_q.start <= 1'b1;
            cctl_q.vec   <= 1'b0;
            state_q      <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (c_done) begin
            mstart_q <= 1'b1;
            state_q  <= ST_RGAIN;
          end
        end
        ST_RGAIN: begin
          if (ma_done && mb_done) begin
            ore_q   <= sat_a;
            oim_q   <= sat_b;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_data_q <= TW'({oim_q, ore_q});
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### sv/sbcr_sermul.sv
// ----------------------------------------------------------------------------
// sbcr_sermul
// bit-serial multiplier, signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module sbcr_sermul #(
  parameter int AW = 32,
  parameter int BW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [BW-1:0]        b_i,
  output logic                 done_o,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int CNTW = $clog2(BW + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNTW-1:0]         cnt_q;
  logic signed [AW-1:0]    a_q;
  logic [BW-1:0]           b_q;
  logic signed [AW+BW-1:0] acc_q;
  logic signed [AW+BW-1:0] addend;

  assign addend = b_q[BW-1] ? (AW+BW)'(a_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q <<< 1) + addend;
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

### sv/sbcr_cordic.sv
// ----------------------------------------------------------------------------
// sbcr_cordic
// iterative cordic, one micro-rotation per cycle, vectoring or rotation
// ----------------------------------------------------------------------------
module sbcr_cordic
  import sbcr_pkg::*;
#(
  parameter int XW    = 32,
  parameter int STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cordic_ctl_t          ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 done_o
);

  logic                 busy_q;
  logic                 done_q;
  logic                 vec_q;
  logic [STEP_W-1:0]    cnt_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, x0, y0, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, z0, at;
  logic                 ccw;

  // quarter-turn preload into the right half plane
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = z_i;
    if (ctl_i.vec) begin
      z0 = '0;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x0 = y_i;
          y0 = -x_i;
          z0 = FINE_HALF_PI;
        end else begin
          x0 = -y_i;
          y0 = x_i;
          z0 = -FINE_HALF_PI;
        end
      end
    end else begin
      if (z_i > FINE_HALF_PI) begin
        x0 = '0;
        y0 = x_i;
        z0 = z_i - FINE_HALF_PI;
      end else if (z_i < -FINE_HALF_PI) begin
        x0 = '0;
        y0 = -x_i;
        z0 = z_i + FINE_HALF_PI;
      end
    end
  end

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    at  = {{(ZW-ATAN_W){1'b0}}, atan_fine(cnt_q)};
    ccw = vec_q ? y_q[XW-1] : !z_q[ZW-1];
    if (ccw) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        vec_q  <= ctl_i.vec;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x0;
      y_q <= y0;
      z_q <= z0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

### test/spectral_bin_crusher_robotiser_top_tb.sv
// ----------------------------------------------------------------------------
// spectral_bin_crusher_robotiser_top_tb
// self-checking bench for the bin crusher / robotiser
// ----------------------------------------------------------------------------
// Bins go in on s_axis and every processed bin coming out of m_axis is
// checked field by field against a bit-exact model of the magnitude hold,
// phase scaling and both cordic passes. Directed bins cover field extremes,
// the +pi and zero bins, register corners and a group shrunk mid group; then
// random frames run under several register settings and handshake patterns.
// ----------------------------------------------------------------------------
module spectral_bin_crusher_robotiser_top_tb
  import sbcr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SW        = 24;
  localparam int     STEPS     = 16;
  localparam int     GMAX      = 64;
  localparam int     DW        = ((2*SW+7)/8)*8;
  localparam int     GUARD     = 4;
  localparam longint GAIN_COMP = 10188014;
  localparam longint HALF_PI   = 4194304;
  localparam longint MAG_MAX   = (longint'(1) << (SW+1)) - 1;
  localparam longint OUT_MAX   = (longint'(1) << (SW-1)) - 1;
  localparam longint OUT_MIN   = -(longint'(1) << (SW-1));
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint ATAN_TAB [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct {
    logic [SW-1:0] re;
    logic [SW-1:0] im;
    int            idx;
  } bin_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DW-1:0]         s_axis_tdata;   // bin_real, bin_imag, zero pad
  logic                  s_axis_tuser;   // frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DW-1:0]         m_axis_tdata;   // out_real, out_imag, zero pad

  // shadow registers and grouping state
  logic [6:0] grp_cfg;
  logic [8:0] amt_cfg;
  longint     grp_pos;
  longint     held_mag;

  bin_out_t expected_bins [$];
  int       n_sent;
  int       n_errors;
  int       src_idle_pct;
  int       snk_stall_pct;
  int       stall_left = 0;

  spectral_bin_crusher_robotiser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic longint unity_gain(longint v);
    return (v * GAIN_COMP + (longint'(1) << (23 + GUARD))) >>> (24 + GUARD);
  endfunction

  function automatic logic [SW-1:0] clip_out(longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[SW-1:0];
  endfunction

  function automatic void to_polar(input longint re, input longint im,
                                   output longint mag, output longint ph);
    longint x, y, z, t, xs, ys;
    int i;
    x = re * 16;
    y = im * 16;
    z = 0;
    if (re == 0 && im == 0) begin
      mag = 0;
      ph  = 0;
      return;
    end
    // pre-rotate by a quarter turn into the right half plane
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
      end
    end
    mag = unity_gain(x);
    if (mag < 0) mag = 0;
    if (mag > MAG_MAX) mag = MAG_MAX;
    ph = (z + 128) >>> 8;
    if (ph > 32768) ph = 32768;
    if (ph < -32768) ph = -32768;
  endfunction

  function automatic void from_polar(input longint mag, input longint ph,
                                     output longint re, output longint im);
    longint x, y, t, xs, ys;
    int i;
    x = mag * 16;
    y = 0;
    t = ph * 256;
    if (t > HALF_PI) begin
      y = x; x = 0; t = t - HALF_PI;
    end else if (t < -HALF_PI) begin
      y = -x; x = 0; t = t + HALF_PI;
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (t >= 0) begin
        x = x - ys; y = y + xs; t = t - ATAN_TAB[i];
      end else begin
        x = x + ys; y = y - xs; t = t + ATAN_TAB[i];
      end
    end
    re = unity_gain(x);
    im = unity_gain(y);
  endfunction

  function automatic bin_out_t crush_bin(logic signed [SW-1:0] re_in,
                                         logic signed [SW-1:0] im_in, logic fs);
    longint gsz, amt, re, im, mag, ph, newph, ore, oim;
    bin_out_t r;
    gsz = grp_cfg;
    amt = amt_cfg;
    re  = re_in;
    im  = im_in;
    if (gsz == 0) gsz = 1;
    if (gsz > GMAX) gsz = GMAX;
    if (amt > 256) amt = 256;
    if (fs) grp_pos = 0;
    to_polar(re, im, mag, ph);
    if (grp_pos == 0) held_mag = mag;
    else mag = held_mag;
    newph = (ph * (256 - amt) + 128) >>> 8;
    from_polar(mag, newph, ore, oim);
    grp_pos++;
    // a shrunk group ends here even when the position ran past the new size
    if (grp_pos >= gsz) grp_pos = 0;
    r.re  = clip_out(ore);
    r.im  = clip_out(oim);
    r.idx = 0;
    return r;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int idx, logic [SW-1:0] got,
                                 logic [SW-1:0] want);
    $display("[%0t] mismatch bin %0d: %s got %h want %h", $realtime, idx, what,
             got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    bin_out_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected result", -1, m_axis_tdata[SW-1:0], '0);
      end else begin
        e = expected_bins.pop_front();
        if (m_axis_tdata[SW-1:0] !== e.re)
          report_mismatch("out_real", e.idx, m_axis_tdata[SW-1:0], e.re);
        if (m_axis_tdata[2*SW-1:SW] !== e.im)
          report_mismatch("out_imag", e.idx, m_axis_tdata[2*SW-1:SW], e.im);
      end
    end
  end

  // receiver backpressure, with occasional long stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_stall_pct != 0 && $urandom_range(0, 49) == 0) begin
      stall_left    <= $urandom_range(1, 120);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // ------------------------------------------------------------ stimulus

  task automatic send_bin(logic [SW-1:0] re, logic [SW-1:0] im, logic fs);
    int gap;
    bin_out_t e;
    gap = 0;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (src_idle_pct != 0 && $urandom_range(0, 19) == 0)
      gap += $urandom_range(1, 120);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DW'({im, re});
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    e     = crush_bin(re, im, fs);
    e.idx = n_sent;
    expected_bins.push_back(e);
    n_sent++;
  endtask

  // hold off the sender until every pending bin has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no extra edge
  task automatic write_reg(cfg_addr_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_GROUP_SIZE) grp_cfg = val[6:0];
    else amt_cfg = val[8:0];
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] gval, logic [CFG_DATA_W-1:0] aval);
    drain();
    write_reg(CFG_GROUP_SIZE, gval);
    write_reg(CFG_ROBOT_AMOUNT, aval);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    int s;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: s = $urandom();
      4:          s = int'($urandom_range(0, 511)) - 256;
      5: begin
        case ($urandom_range(0, 4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       s = -1;
          3:       s = 1;
          default: s = 0;
        endcase
      end
      6: begin
        s = $urandom();
        s = s >>> (8 + $urandom_range(0, 20));
      end
      default: s = 0;
    endcase
    return s[SW-1:0];
  endfunction

  // frames mostly open with frame_start; a few are broken or restart early
  task automatic run_frames(int n_bins);
    int sent, flen, k, gsz;
    logic fs;
    sent = 0;
    while (sent < n_bins) begin
      gsz = (grp_cfg == 0) ? 1 : (grp_cfg > GMAX) ? GMAX : grp_cfg;
      flen = $urandom_range(1, 2*gsz + 3);
      for (k = 0; k < flen && sent < n_bins; k++) begin
        fs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
        send_bin(pick_sample(), pick_sample(), fs);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings, no frame start on the first bin; +pi and zero bins
  task automatic test_field_extremes();
    send_bin('0, '0, 1'b0);
    send_bin(S_MAX, '0, 1'b0);
    send_bin(S_MIN, '0, 1'b1);
    send_bin('0, S_MAX, 1'b0);
    send_bin('0, S_MIN, 1'b0);
    send_bin(S_MAX, S_MAX, 1'b1);
    send_bin(S_MIN, S_MIN, 1'b0);
    send_bin(S_MIN, S_MAX, 1'b0);
    send_bin(S_MAX, S_MIN, 1'b0);
    send_bin('1, '0, 1'b0);
    send_bin(SW'(1), SW'(1), 1'b0);
    send_bin('1, '1, 1'b1);
  endtask

  // group size zero and oversize, amount at and above one, unused data bits
  task automatic test_register_corners();
    set_regs(9'd0, 9'd256);
    send_bin(S_MIN, SW'(1), 1'b1);
    send_bin(SW'(12345), S_MIN, 1'b0);
    set_regs(9'd100, 9'd511);
    send_bin(S_MAX, SW'(-77), 1'b1);
    send_bin(SW'(5), SW'(900000), 1'b0);
    send_bin(S_MIN, S_MIN, 1'b0);
    set_regs(9'h181, 9'd300);
    send_bin(SW'(-4000), SW'(70000), 1'b0);
  endtask

  // group shrunk below the current position: bin keeps the held magnitude
  task automatic test_group_shrink();
    set_regs(9'd4, 9'd64);
    send_bin(SW'(3000000), SW'(-1000000), 1'b1);
    send_bin(SW'(10), SW'(-20), 1'b0);
    send_bin(S_MIN, SW'(400), 1'b0);
    set_regs(9'd2, 9'd64);
    send_bin(SW'(-2500), SW'(8000), 1'b0);
    send_bin(SW'(600000), SW'(600000), 1'b0);
  endtask

  task automatic test_random_frames();
    int ph, c;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 80; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 80; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      for (c = 0; c < 5; c++) begin
        case (c)
          0:       set_regs(9'd1, 9'd0);
          1:       set_regs(9'd64, 9'd256);
          2:       set_regs(CFG_DATA_W'($urandom_range(2, 8)),
                            CFG_DATA_W'($urandom_range(0, 256)));
          3:       set_regs(CFG_DATA_W'($urandom_range(0, 511)),
                            CFG_DATA_W'($urandom_range(0, 511)));
          default: set_regs(CFG_DATA_W'($urandom_range(1, 64)), 9'd128);
        endcase
        run_frames(70);
      end
    end
  endtask

  initial begin
    int waited;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= CFG_GROUP_SIZE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    n_sent        = 0;
    n_errors      = 0;
    grp_cfg       = 7'd1;
    amt_cfg       = 9'd0;
    grp_pos       = 0;
    held_mag      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_register_corners();
    test_group_shrink();
    test_random_frames();

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_bins.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_bins.size() != 0)
      report_mismatch("results missing", expected_bins.size(), '0, '0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
sv/sbcr_pkg.sv
sv/sbcr_sermul.sv
sv/sbcr_cordic.sv
sv/spectral_bin_crusher_robotiser_top.sv
test/spectral_bin_crusher_robotiser_top_tb.sv
